@@ sv/cpr_pkg.sv @@
// shared constants and types for the clock page replacement block
package cpr_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int PAGE_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_FRAMES);
	localparam int CNT_W      = 4;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [CNT_W-1:0] FRAMES_RESET = CNT_W'(MAX_FRAMES);

	// register select: paddr[2] picks the register slot
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP,
		ST_DONE
	} cpr_state_t;

endpackage

@@ sv/clock_page_replacement_top.sv @@
// clock page replacement: frame table, clock hand sweep and register port
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    page_number
// out      output     out_valid / out_stall  hit, frame_index, evicted_valid, evicted_page
// cfg      input      apb psel/penable       paddr, pwdata, prdata
//
// a hit steps through accept, one parallel tag compare and result load
// a miss adds a sweep after the compare: the hand advances one frame per cycle through a
// single increment and wrap unit until a free or unreferenced frame
// reset clears the hand, all occupied and reference bits, frames_in_use goes to 8
// in_stall is high from the transfer until the result sits in the output register;
// a result held by out_stall blocks only the load of the following result
module clock_page_replacement_top
	import cpr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output logic [IDX_W-1:0]     frame_index,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready
);

	cpr_state_t state_q, state_d;

	logic [CNT_W-1:0]     frames_q;
	logic [IDX_W-1:0]     hand_q;
	logic [MAX_FRAMES-1:0] occ_q;
	logic [MAX_FRAMES-1:0] ref_q;
	logic [PAGE_BITS-1:0] page_q [MAX_FRAMES];
	logic [PAGE_BITS-1:0] cur_page_q;

	logic                 res_hit_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic                 res_ev_q;
	logic [PAGE_BITS-1:0] res_evpage_q;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     frame_index_q;
	logic                 evicted_valid_q;
	logic [PAGE_BITS-1:0] evicted_page_q;

	logic [CNT_W-1:0] active_n;
	logic             hand_oor;
	logic [CNT_W-1:0] hand_inc;
	logic [IDX_W-1:0] hand_next;
	logic             lookup_hit;
	logic [IDX_W-1:0] lookup_idx;
	logic             slot_free;
	logic             in_xfer;
	logic             out_xfer;
	logic             out_load;
	logic             cfg_wr;

	// frame count with zero and overflow clamped
	always_comb begin
		if (frames_q == '0) begin
			active_n = CNT_W'(1);
		end else if (frames_q > CNT_W'(MAX_FRAMES)) begin
			active_n = CNT_W'(MAX_FRAMES);
		end else begin
			active_n = frames_q;
		end
	end

	// single hand increment and wrap unit
	assign hand_oor  = {1'b0, hand_q} >= active_n;
	assign hand_inc  = {1'b0, hand_q} + CNT_W'(1);
	assign hand_next = (hand_inc == active_n) ? '0 : hand_inc[IDX_W-1:0];
	assign slot_free = !occ_q[hand_q] || !ref_q[hand_q];

	// parallel tag compare, lowest matching frame wins
	always_comb begin
		lookup_hit = 1'b0;
		lookup_idx = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < active_n) && occ_q[i] && (page_q[i] == cur_page_q)) begin
				lookup_hit = 1'b1;
				lookup_idx = IDX_W'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_d = lookup_hit ? ST_DONE : ST_SWEEP;
			end
			ST_SWEEP: begin
				if (slot_free) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_LOOKUP: in_stall = 1'b1;
			ST_SWEEP:  in_stall = 1'b1;
			ST_DONE:   out_load = !out_valid_q || !out_stall;
			default:   in_stall = 1'b1;
		endcase
	end

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frames_q    <= FRAMES_RESET;
			hand_q      <= '0;
			occ_q       <= '0;
			ref_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && (paddr[2] == REG_FRAMES_IN_USE)) begin
				frames_q <= pwdata[CNT_W-1:0];
			end
			if (state_q == ST_LOOKUP) begin
				if (lookup_hit) begin
					ref_q[lookup_idx] <= 1'b1;
				end
				if (hand_oor) begin
					hand_q <= '0;
				end
			end
			if (state_q == ST_SWEEP) begin
				hand_q <= hand_next;
				if (slot_free) begin
					occ_q[hand_q] <= 1'b1;
					ref_q[hand_q] <= 1'b1;
				end else begin
					ref_q[hand_q] <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_page_q <= page_number;
		end
		if (state_q == ST_LOOKUP) begin
			res_hit_q    <= lookup_hit;
			res_idx_q    <= lookup_idx;
			res_ev_q     <= 1'b0;
			res_evpage_q <= '0;
		end
		if ((state_q == ST_SWEEP) && slot_free) begin
			page_q[hand_q] <= cur_page_q;
			res_idx_q      <= hand_q;
			res_ev_q       <= occ_q[hand_q];
			res_evpage_q   <= occ_q[hand_q] ? page_q[hand_q] : '0;
		end
		if (out_load) begin
			hit_q           <= res_hit_q;
			frame_index_q   <= res_idx_q;
			evicted_valid_q <= res_ev_q;
			evicted_page_q  <= res_evpage_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? APB_DW'(frames_q) : '0;

endmodule

@@ tb/clock_page_replacement_top_tb.sv @@
// self-checking testbench for the clock page replacement block
`timescale 1ns / 100ps

module clock_page_replacement_top_tb;
	import cpr_pkg::*;

	localparam logic [APB_AW-1:0] FRAMES_ADDR = {REG_FRAMES_IN_USE, 2'b00};
	localparam logic [APB_AW-1:0] SPARE_ADDR  = {~REG_FRAMES_IN_USE, 2'b00};
	localparam int unsigned       CYCLE_LIMIT = 400000;
	localparam int unsigned       PHASE_ITEMS = 48;

	typedef struct packed {
		logic                 hit;
		logic [IDX_W-1:0]     frame;
		logic                 evicted;
		logic [PAGE_BITS-1:0] evicted_page;
	} access_outcome_t;

	class frame_table_tracker;
		logic [PAGE_BITS-1:0] resident_page [MAX_FRAMES];
		bit                   ref_bit [MAX_FRAMES];
		bit                   occupied [MAX_FRAMES];
		int unsigned          hand;
		logic [CNT_W-1:0]     frames_reg;
		access_outcome_t      awaited [$];
		int unsigned          errors;

		function new();
			for (int i = 0; i < MAX_FRAMES; i++) begin
				resident_page[i] = '0;
				ref_bit[i] = 1'b0;
				occupied[i] = 1'b0;
			end
			hand = 0;
			frames_reg = FRAMES_RESET;
			errors = 0;
		endfunction

		function int unsigned active_frames();
			if (frames_reg == 0)
				return 1;
			if (frames_reg > MAX_FRAMES)
				return MAX_FRAMES;
			return frames_reg;
		endfunction

		function void write_register(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
			if (addr[2] == REG_FRAMES_IN_USE)
				frames_reg = data[CNT_W-1:0];
		endfunction

		function void note_access(logic [PAGE_BITS-1:0] page);
			int unsigned     n;
			int unsigned     victim;
			access_outcome_t o;
			n = active_frames();
			if (hand >= n)
				hand = 0;
			for (int i = 0; i < n; i++) begin
				if (occupied[i] && resident_page[i] == page) begin
					ref_bit[i] = 1'b1;
					o.hit = 1'b1;
					o.frame = IDX_W'(i);
					o.evicted = 1'b0;
					o.evicted_page = '0;
					awaited.push_back(o);
					return;
				end
			end
			// second chance sweep, one full lap clears every bit
			for (int s = 0; s <= n; s++) begin
				if (!occupied[hand] || !ref_bit[hand])
					break;
				ref_bit[hand] = 1'b0;
				hand = (hand + 1) % n;
			end
			victim = hand;
			o.hit = 1'b0;
			o.frame = IDX_W'(victim);
			o.evicted = occupied[victim];
			o.evicted_page = occupied[victim] ? resident_page[victim] : '0;
			resident_page[victim] = page;
			occupied[victim] = 1'b1;
			ref_bit[victim] = 1'b1;
			hand = (victim + 1) % n;
			awaited.push_back(o);
		endfunction

		function void check_result(logic h, logic [IDX_W-1:0] f, logic ev,
				logic [PAGE_BITS-1:0] evp);
			access_outcome_t got;
			access_outcome_t want;
			got.hit = h;
			got.frame = f;
			got.evicted = ev;
			got.evicted_page = evp;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer: hit=%0d frame=%0d evicted=%0d page=%h",
						h, f, ev, evp);
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected hit=%0d frame=%0d evicted=%0d page=%h, ",
						"got hit=%0d frame=%0d evicted=%0d page=%h"},
						want.hit, want.frame, want.evicted, want.evicted_page,
						h, f, ev, evp);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PAGE_BITS-1:0] page_number = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 hit;
	logic [IDX_W-1:0]     frame_index;
	logic                 evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [APB_AW-1:0]    paddr = '0;
	logic [APB_DW-1:0]    pwdata = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	frame_table_tracker   tracker = new();
	bit                   calm = 1'b0;
	int unsigned          holdoff_len = 0;
	int unsigned          cycle_count = 0;
	logic [PAGE_BITS-1:0] pool_base = '0;

	clock_page_replacement_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.frame_index  (frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			tracker.note_access(page_number);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(hit, frame_index, evicted_valid, evicted_page);
	end

	// receiver side: random stalls, quiet stretches and one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (holdoff_len > 0) begin
				out_stall <= 1'b1;
				holdoff_len--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 35);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[clock_page_replacement_top] ERROR");
		$finish;
	end

	task automatic offer_page(input logic [PAGE_BITS-1:0] page);
		in_valid <= 1'b1;
		page_number <= page;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic idle_sender();
		int unsigned gap;
		gap = 0;
		while (!calm && $urandom_range(99) < 35)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			page_number <= PAGE_BITS'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_page(input logic [PAGE_BITS-1:0] page);
		offer_page(page);
		idle_sender();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.write_register(addr, data);
	endtask

	task automatic set_frames(input logic [CNT_W-1:0] count);
		write_reg(FRAMES_ADDR, {(APB_DW-CNT_W)'($urandom), count});
	endtask

	function automatic logic [PAGE_BITS-1:0] pick_page(int unsigned span);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return pool_base + PAGE_BITS'($urandom_range(span + 2));
		if (r < 90)
			return PAGE_BITS'($urandom);
		return r[0] ? '1 : '0;
	endfunction

	initial begin
		logic [CNT_W-1:0] counts [10];
		counts = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd3, 4'd8, 4'd2, 4'd7, 4'd4};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill all frames, hit, then a miss that sweeps a full lap
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h0000);
		send_page(16'hAAAA);
		send_page(16'h5555);
		send_page(16'h0001);
		send_page(16'h8000);
		send_page(16'h7FFF);
		send_page(16'h1234);
		send_page(16'h0000);
		send_page(16'h4321);
		send_page(16'hFFFF);
		drain_results();
		// zero count acts as one frame
		set_frames('0);
		send_page(16'h0101);
		send_page(16'h0101);
		send_page(16'h0202);
		drain_results();
		// count above the table size saturates
		set_frames('1);
		send_page(16'h0202);
		send_page(16'h1234);
		send_page(16'h0303);
		drain_results();
		// write to a missing register is ignored
		write_reg(SPARE_ADDR, APB_DW'(1));
		send_page(16'h0404);
		drain_results();
		// shrink with the hand beyond the count, then grow to expose a duplicate
		set_frames(CNT_W'(3));
		send_page(16'h7FFF);
		send_page(16'h0303);
		drain_results();
		set_frames(CNT_W'(8));
		send_page(16'h7FFF);
		drain_results();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 6)
				write_reg(SPARE_ADDR, APB_DW'($urandom));
			set_frames(ph == 9 ? CNT_W'($urandom) : counts[ph]);
			pool_base = PAGE_BITS'($urandom);
			calm = (ph == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 2 && k == 5)
					holdoff_len = 300;
				if (ph == 6 && k == 24)
					drain_results();
				send_page(pick_page(tracker.active_frames()));
			end
			drain_results();
		end
		calm = 1'b0;

		drain_results();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.awaited.size() == 0)
			$display("[clock_page_replacement_top] OK");
		else
			$display("[clock_page_replacement_top] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
sv/cpr_pkg.sv
sv/clock_page_replacement_top.sv
tb/clock_page_replacement_top_tb.sv
